[hw/rtl/hri_pkg.sv]
// Package for the Halton radical inverse generator.
// Holds field widths and internal datapath widths shared by all files.
// No dependencies.
package hri_pkg;

  localparam int unsigned IDX_W  = 31;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned BASE_W = 6;
  localparam int unsigned FRAC_W = 32;

  // Denominator b^m stays below 2^37 for any index below 2^31 and base below 64.
  localparam int unsigned DEN_W  = 37;

  // Digit store: at most 31 digits, addressed with 5 bits.
  localparam int unsigned DIG_AW = 5;
  localparam int unsigned DIG_N  = 32;

  localparam logic [BASE_W-1:0] MIN_BASE   = BASE_W'(2);
  localparam logic [BASE_W-1:0] RESET_BASE = BASE_W'(2);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BASE_W-1:0] base_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [DEN_W-1:0]  den_t;

endpackage

[hw/rtl/hri_intf.sv]
// Valid/ready channel interfaces of the Halton radical inverse generator.
// Input run requests, output values and the base register write channel.
// Depends on hri_pkg.
interface hri_in_if;
  import hri_pkg::*;

  logic valid;
  logic ready;
  idx_t start_index;
  len_t run_length;

  modport source (output valid, output start_index, output run_length, input ready);
  modport sink   (input valid, input start_index, input run_length, output ready);
endinterface

interface hri_out_if;
  import hri_pkg::*;

  logic  valid;
  logic  ready;
  idx_t  seq_index;
  frac_t fraction;
  logic  last_of_run;

  modport source (output valid, output seq_index, output fraction, output last_of_run,
                  input ready);
  modport sink   (input valid, input seq_index, input fraction, input last_of_run,
                  output ready);
endinterface

interface hri_cfg_if;
  import hri_pkg::*;

  logic  valid;
  logic  ready;
  base_t radix_base;

  modport source (output valid, output radix_base, input ready);
  modport sink   (input valid, input radix_base, output ready);
endinterface

[hw/rtl/hri_div_step.sv]
// One restoring division step: shift in a bit, compare and subtract.
// Shared by the digit extraction and the fraction long division.
// Depends on hri_pkg.
module hri_div_step (
  input  logic [hri_pkg::DEN_W-1:0] rem_i,
  input  logic                      bit_i,
  input  logic [hri_pkg::DEN_W-1:0] div_i,
  output logic [hri_pkg::DEN_W-1:0] rem_o,
  output logic                      quo_bit_o
);
  import hri_pkg::*;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] divisor;
  logic [DEN_W:0] diff;

  assign shifted   = {rem_i, bit_i};
  assign divisor   = {1'b0, div_i};
  assign diff      = shifted - divisor;
  assign quo_bit_o = (shifted >= divisor);
  assign rem_o     = quo_bit_o ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

endmodule

[hw/rtl/halton_radical_inverse.sv]
// Top level of the Halton radical inverse generator.
// Depends on hri_pkg, the channel interfaces in hri_intf and hri_div_step.
//
// Usage: a run request on in_i (start_index, run_length) yields run_length
// values on out_o, one per index, each carrying seq_index, the radical inverse
// as a truncated unsigned fraction, and last_of_run on the final one. A
// run_length above MAX_RUN is cut to MAX_RUN; zero produces nothing. The base
// is written over cfg_i between runs; values 0 and 1 act as base 2.
// in_i is ready only while no run is in progress. The start index is first
// split into its m base-b digits through one shared compare-subtract stage.
// Each value then goes through digit reversal on a 37x6 multiplier, long
// division of FRAC_BITS quotient bits on the same compare-subtract stage, a
// hand-off of the result, and an increment that steps through each digit the
// carry passes through. A finished value sits in an output register; a stalled
// receiver holds the run at its hand-off step until the register frees up. Reset
// empties the output register, ends any run and sets the base to 2.
module halton_radical_inverse #(
  parameter int unsigned MAX_RUN   = 64,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hri_cfg_if.sink       cfg_i,
  hri_in_if.sink        in_i,
  hri_out_if.source     out_o
);
  import hri_pkg::*;

  localparam int unsigned CW = ($clog2(FRAC_BITS) > 5) ? $clog2(FRAC_BITS) : 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIV,
    ST_HORN,
    ST_FRAC,
    ST_EMIT,
    ST_INC
  } state_e;

  state_e                  state_q, state_d;
  base_t                   cfg_base_q, cfg_base_d;
  base_t                   base_q, base_d;
  idx_t                    idx_q, idx_d;
  len_t                    remain_q, remain_d;
  idx_t                    work_q, work_d;
  den_t                    acc_q, acc_d;
  den_t                    den_q, den_d;
  logic [FRAC_BITS-1:0]    quo_q, quo_d;
  logic [DIG_AW-1:0]       m_q, m_d;
  logic [DIG_AW-1:0]       k_q, k_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  idx_t                    out_idx_q, out_idx_d;
  frac_t                   out_frac_q, out_frac_d;
  logic                    out_last_q, out_last_d;

  base_t                   digits_q [DIG_N];
  logic                    dig_we;
  logic [DIG_AW-1:0]       dig_waddr;
  base_t                   dig_wdata;
  base_t                   dig_rd;

  logic                    step_bit;
  den_t                    step_div;
  den_t                    step_rem;
  logic                    step_quo;
  den_t                    mul_a;
  logic [DEN_W+BASE_W-1:0] mul_prod;
  den_t                    mul_lo;
  frac_t                   frac_out;
  len_t                    len_eff;

  hri_div_step u_div_step (
    .rem_i     (acc_q),
    .bit_i     (step_bit),
    .div_i     (step_div),
    .rem_o     (step_rem),
    .quo_bit_o (step_quo)
  );

  assign step_bit = (state_q == ST_DIV) ? work_q[IDX_W-1] : 1'b0;
  assign step_div = (state_q == ST_DIV) ? DEN_W'(base_q) : den_q;

  assign mul_a    = (state_q == ST_HORN) ? acc_q : den_q;
  assign mul_prod = mul_a * base_q;
  assign mul_lo   = mul_prod[DEN_W-1:0];

  assign dig_rd   = digits_q[k_q];

  generate
    if (FRAC_BITS >= FRAC_W) begin : g_frac_trunc
      assign frac_out = quo_q[FRAC_W-1:0];
    end else begin : g_frac_ext
      assign frac_out = {{(FRAC_W-FRAC_BITS){1'b0}}, quo_q};
    end
  endgenerate

  assign len_eff = (in_i.run_length > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : in_i.run_length;

  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.seq_index   = out_idx_q;
  assign out_o.fraction    = out_frac_q;
  assign out_o.last_of_run = out_last_q;

  always_comb begin
    state_d     = state_q;
    cfg_base_d  = cfg_base_q;
    base_d      = base_q;
    idx_d       = idx_q;
    remain_d    = remain_q;
    work_d      = work_q;
    acc_d       = acc_q;
    den_d       = den_q;
    quo_d       = quo_q;
    m_d         = m_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_frac_d  = out_frac_q;
    out_last_d  = out_last_q;
    dig_we      = 1'b0;
    dig_waddr   = k_q;
    dig_wdata   = '0;

    if (cfg_i.valid) begin
      cfg_base_d = cfg_i.radix_base;
    end
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          base_d   = (cfg_base_q < MIN_BASE) ? MIN_BASE : cfg_base_q;
          idx_d    = in_i.start_index;
          work_d   = in_i.start_index;
          remain_d = len_eff;
          m_d      = '0;
          den_d    = DEN_W'(1);
          if (len_eff != '0) begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        acc_d = '0;
        cnt_d = '0;
        k_d   = '0;
        if (work_q == '0) begin
          state_d = ST_HORN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        acc_d  = step_rem;
        work_d = {work_q[IDX_W-2:0], step_quo};
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(IDX_W-1)) begin
          dig_we    = 1'b1;
          dig_waddr = m_q;
          dig_wdata = step_rem[BASE_W-1:0];
          m_d       = m_q + DIG_AW'(1);
          den_d     = mul_lo;
          state_d   = ST_CONV;
        end
      end
      ST_HORN: begin
        if (k_q == m_q) begin
          cnt_d   = '0;
          quo_d   = '0;
          state_d = ST_FRAC;
        end else begin
          acc_d = mul_lo + DEN_W'(dig_rd);
          k_d   = k_q + DIG_AW'(1);
        end
      end
      ST_FRAC: begin
        acc_d = step_rem;
        quo_d = {quo_q[FRAC_BITS-2:0], step_quo};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(FRAC_BITS-1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = idx_q;
          out_frac_d  = frac_out;
          out_last_d  = (remain_q == LEN_W'(1));
          remain_d    = remain_q - LEN_W'(1);
          idx_d       = idx_q + IDX_W'(1);
          acc_d       = '0;
          k_d         = '0;
          if (remain_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end else if (idx_q == '1) begin
            m_d     = '0;
            den_d   = DEN_W'(1);
            state_d = ST_HORN;
          end else begin
            state_d = ST_INC;
          end
        end
      end
      ST_INC: begin
        dig_we    = 1'b1;
        dig_waddr = k_q;
        if (k_q == m_q) begin
          dig_wdata = base_t'(1);
          m_d       = m_q + DIG_AW'(1);
          den_d     = mul_lo;
          k_d       = '0;
          state_d   = ST_HORN;
        end else if (dig_rd == (base_q - base_t'(1))) begin
          dig_wdata = '0;
          k_d       = k_q + DIG_AW'(1);
        end else begin
          dig_wdata = dig_rd + base_t'(1);
          k_d       = '0;
          state_d   = ST_HORN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_base_q  <= RESET_BASE;
      base_q      <= RESET_BASE;
      idx_q       <= '0;
      remain_q    <= '0;
      work_q      <= '0;
      acc_q       <= '0;
      den_q       <= DEN_W'(1);
      quo_q       <= '0;
      m_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_frac_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_base_q  <= cfg_base_d;
      base_q      <= base_d;
      idx_q       <= idx_d;
      remain_q    <= remain_d;
      work_q      <= work_d;
      acc_q       <= acc_d;
      den_q       <= den_d;
      quo_q       <= quo_d;
      m_q         <= m_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_frac_q  <= out_frac_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[dig_waddr] <= dig_wdata;
    end
  end

endmodule

[hw/rtl/hri_checker.sv]
// Port-level checks for the Halton radical inverse generator.
// Bound to halton_radical_inverse; depends on hri_pkg.
// Watches the output channel for ordering and handshake behavior.
module hri_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input hri_pkg::idx_t      seq_index_i,
  input hri_pkg::frac_t     fraction_i,
  input logic               last_of_run_i
);
  import hri_pkg::*;

  logic out_xfer;
  logic in_run_q;
  idx_t prev_idx_q;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q   <= 1'b0;
      prev_idx_q <= '0;
    end else if (out_xfer) begin
      in_run_q   <= !last_of_run_i;
      prev_idx_q <= seq_index_i;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output valid dropped before the transfer.");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(seq_index_i) && $stable(fraction_i)
                                    && $stable(last_of_run_i))
    else $error("Output payload changed while stalled.");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_run_q |-> seq_index_i == prev_idx_q + IDX_W'(1))
    else $error("Sequence index did not advance by one within a run.");

  a_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seq_index_i == '0 |-> fraction_i == '0)
    else $error("Index zero gave a nonzero fraction.");

endmodule

bind halton_radical_inverse hri_checker u_hri_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .seq_index_i   (out_o.seq_index),
  .fraction_i    (out_o.fraction),
  .last_of_run_i (out_o.last_of_run)
);

[tb/hri_checker.sv]
// Scoreboard for the Halton radical inverse generator: snoops the base register
// writes, run requests and value transfers, predicts every value and compares.
// Depends on hri_pkg and the channel interfaces in hri_intf.
module hri_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  hri_cfg_if   cfg_mon_i,
  hri_in_if    run_mon_i,
  hri_out_if   val_mon_i,
  output int   mismatch_count_o,
  output int   open_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hri_pkg::*;

  localparam int unsigned RUN_CAP = 64;

  typedef struct packed {
    idx_t  seq_index;
    frac_t fraction;
    logic  last_of_run;
  } halton_value_t;

  halton_value_t value_q[$];
  halton_value_t want, got;
  base_t         base_copy;
  idx_t          walk_index;
  int unsigned   run_count;
  int            fail_total;

  assign mismatch_count_o = fail_total;

  // Reverses the base-b digits of idx behind the radix point and returns
  // floor(value * 2^32), found by exact long division.
  function automatic frac_t radical_inverse_q32(idx_t idx, base_t radix);
    logic [63:0] rest, rev, den, b;
    frac_t       q;
    b = (radix < MIN_BASE) ? 64'(MIN_BASE) : 64'(radix);
    rest = 64'(idx);
    rev = '0;
    den = 64'd1;
    q = '0;
    while (rest != 0) begin
      rev = rev * b + (rest % b);
      den = den * b;
      rest = rest / b;
    end
    for (int k = 0; k < FRAC_W; k++) begin
      rev = rev << 1;
      q = {q[FRAC_W-2:0], 1'b0};
      if (rev >= den) begin
        rev = rev - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  initial fail_total = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q.delete();
      base_copy = RESET_BASE;
      open_count_o <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        base_copy = cfg_mon_i.radix_base;
      end
      if (run_mon_i.valid && run_mon_i.ready) begin
        run_count = (run_mon_i.run_length > RUN_CAP) ? RUN_CAP : run_mon_i.run_length;
        walk_index = run_mon_i.start_index;
        for (int unsigned k = 0; k < run_count; k++) begin
          want.seq_index = walk_index;
          want.fraction = radical_inverse_q32(walk_index, base_copy);
          want.last_of_run = (k == run_count - 1);
          value_q = {value_q, want};
          walk_index = walk_index + 1'b1;
        end
      end
      if (val_mon_i.valid && val_mon_i.ready) begin
        got.seq_index = val_mon_i.seq_index;
        got.fraction = val_mon_i.fraction;
        got.last_of_run = val_mon_i.last_of_run;
        if (value_q.size() == 0) begin
          $error("Unexpected value transfer: seq_index %0d fraction %08h last_of_run %0b",
                 got.seq_index, got.fraction, got.last_of_run);
          fail_total++;
        end else begin
          want = value_q.pop_front();
          if (got.seq_index !== want.seq_index) begin
            $error("seq_index: expected %0d, actual %0d", want.seq_index, got.seq_index);
            fail_total++;
          end
          if (got.fraction !== want.fraction) begin
            $error("fraction: expected %08h, actual %08h (seq_index %0d)",
                   want.fraction, got.fraction, want.seq_index);
            fail_total++;
          end
          if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b (seq_index %0d)",
                   want.last_of_run, got.last_of_run, want.seq_index);
            fail_total++;
          end
        end
      end
      open_count_o <= value_q.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the Halton radical inverse testbench: clock, reset, base writes,
// run requests and output back-pressure; the verdict comes from hri_scoreboard.
// Depends on hri_pkg, hri_intf, halton_radical_inverse and hri_scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hri_pkg::*;

  localparam int SETTLE_CYCLES  = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam idx_t TOP_INDEX    = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_count;
  int   open_count;
  int   quiet_cycles;
  int   stall_left;
  int   in_gap_pct;
  int   out_stall_pct;
  logic calm;

  hri_cfg_if cfg_ch ();
  hri_in_if  run_ch ();
  hri_out_if val_ch ();

  halton_radical_inverse uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (run_ch),
    .out_o  (val_ch)
  );

  hri_scoreboard scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_mon_i        (cfg_ch),
    .run_mon_i        (run_ch),
    .val_mon_i        (val_ch),
    .mismatch_count_o (mismatch_count),
    .open_count_o     (open_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (calm) begin
      val_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      val_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      val_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      val_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((run_ch.valid && run_ch.ready) || (val_ch.valid && val_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_run(input idx_t first, input len_t count);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      run_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    run_ch.valid <= 1'b1;
    run_ch.start_index <= first;
    run_ch.run_length <= count;
    do @(posedge clk_i); while (!run_ch.ready);
  endtask

  task automatic drain_values();
    run_ch.valid <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
  endtask

  task automatic write_base(input base_t radix);
    drain_values();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix_base <= radix;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_run();
    idx_t first;
    len_t count;
    int   pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) first = idx_t'($urandom_range(0, 1000));
    else if (pick == 1) first = TOP_INDEX - idx_t'($urandom_range(0, 200));
    else first = idx_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 78) count = len_t'($urandom_range(1, 8));
    else if (pick < 90) count = len_t'($urandom_range(9, 64));
    else if (pick < 95) count = len_t'($urandom_range(65, 127));
    else count = '0;
    send_run(first, count);
  endtask

  initial begin
    base_t phase_base [6];
    rst_ni <= 1'b0;
    calm <= 1'b0;
    in_gap_pct <= 20;
    out_stall_pct <= 20;
    run_ch.valid <= 1'b0;
    run_ch.start_index <= '0;
    run_ch.run_length <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.radix_base <= '0;
    phase_base = '{base_t'(3), base_t'(63), base_t'(5), base_t'($urandom_range(0, 63)),
                   base_t'(7), base_t'(2)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed runs at the reset base.
    send_run('0, len_t'(1));
    send_run('0, len_t'(64));
    send_run(TOP_INDEX, len_t'(3));
    send_run(idx_t'(31'h7FFF_FFBF), len_t'(64));
    send_run(idx_t'(5), '0);
    send_run(idx_t'(100), len_t'(127));
    send_run(idx_t'(1000), len_t'(65));
    send_run(idx_t'(31'h5555_5555), len_t'(2));
    send_run(idx_t'(31'h2AAA_AAAA), len_t'(2));
    send_run(idx_t'(31'h4000_0000), len_t'(1));
    // Bases below two behave as base two.
    write_base('0);
    send_run(idx_t'(12345), len_t'(4));
    send_run(TOP_INDEX, len_t'(2));
    write_base(base_t'(1));
    send_run(idx_t'(7), len_t'(5));
    send_run('0, '0);
    // Largest base.
    write_base(base_t'(63));
    send_run(TOP_INDEX, len_t'(2));
    send_run('0, len_t'(3));
    send_run(idx_t'(62), len_t'(4));
    send_run(idx_t'(3968), len_t'(3));
    send_run(idx_t'(31'h7FFF_FFC0), len_t'(64));

    for (int phase = 0; phase < 6; phase++) begin
      write_base(phase_base[phase]);
      calm <= (phase == 5);
      in_gap_pct <= (phase == 2) ? 0 : $urandom_range(5, 40);
      out_stall_pct <= (phase == 3) ? 0 : $urandom_range(5, 40);
      for (int k = 0; k < 20; k++) begin
        if (phase == 1 && k == 10) drain_values();
        random_run();
      end
    end

    drain_values();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
